// ===== design/zdpr_pkg.sv =====
// Shared types, constants and helpers for the zero-delimited packet router.
`default_nettype none
package zdpr_pkg;

	localparam int NUM_PORTS = 6;
	localparam int MASK_W = 6;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [MASK_W-1:0] LIVE_MASK =
		(NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

	localparam logic [7:0] ERR_FIRST = 8'd1;

	// register indexes on the config port
	localparam logic [2:0] REG_FIRST_TO   = 3'd0;
	localparam logic [2:0] REG_HEADER_TO  = 3'd1;
	localparam logic [2:0] REG_BCAST_TO   = 3'd2;
	localparam logic [2:0] REG_BODY_TO    = 3'd3;
	localparam logic [2:0] REG_DISCARD_TO = 3'd4;
	localparam logic [2:0] REG_BCAST_CODE = 3'd5;

	localparam logic [7:0] RST_FIRST_TO   = 8'd2;
	localparam logic [7:0] RST_HEADER_TO  = 8'd3;
	localparam logic [7:0] RST_BCAST_TO   = 8'd5;
	localparam logic [7:0] RST_BODY_TO    = 8'd20;
	localparam logic [7:0] RST_DISCARD_TO = 8'd20;
	localparam logic [7:0] RST_BCAST_CODE = 8'd15;

	typedef struct packed {
		logic        operation;
		logic [7:0]  data_byte;
		logic [5:0]  connected_mask;
	} host_word_t;

	typedef struct packed {
		logic [5:0]  port_mask;
		logic [7:0]  out_byte;
		logic        last;
	} port_word_t;

	typedef struct packed {
		logic [7:0] first_to;
		logic [7:0] header_to;
		logic [7:0] bcast_to;
		logic [7:0] body_to;
		logic [7:0] discard_to;
		logic [7:0] bcast_code;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_BODY  = 2'd0,
		CMD_UNI   = 2'd1,
		CMD_BCAST = 2'd2
	} cmd_kind_t;

	// one queued job for the back end
	typedef struct packed {
		cmd_kind_t          kind;
		logic [MASK_W-1:0]  mask;
		logic [7:0]         byte0;   // body byte or overhead byte
		logic [7:0]         cfg;     // header config byte
		logic [15:0]        cs;      // broadcast checksum
	} cmd_t;

	typedef struct packed {
		logic  valid;
		cmd_t  cmd;
	} push_t;

	function automatic logic [MASK_W-1:0] live_ports(input logic [MASK_W-1:0] conn);
		return conn & LIVE_MASK;
	endfunction

endpackage
`default_nettype wire

// ===== design/zdpr_queue.sv =====
// Small command queue between the parser and the result generator.
`default_nettype none
module zdpr_queue #(
	parameter int DEPTH = zdpr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire zdpr_pkg::push_t push,
	input  wire logic           pop,
	output zdpr_pkg::cmd_t      head,
	output logic                nonempty,
	output logic                full
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	zdpr_pkg::cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full     = (count_q == CNT_FULL);
	assign nonempty = (count_q != '0);
	assign do_push  = push.valid && !full;
	assign do_pop   = pop && nonempty;
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

endmodule
`default_nettype wire

// ===== design/zdpr_front.sv =====
// Packet parser: takes host words and ticks, tracks phase, queues output jobs.
`default_nettype none
module zdpr_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire zdpr_pkg::cfg_t       cfg,
	input  wire logic                 host_valid,
	input  wire zdpr_pkg::host_word_t host_word,
	output logic                      host_stall,
	input  wire logic                 q_full,
	output zdpr_pkg::push_t           push
);
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_FIRST    = 3'd1,
		PH_RETRY    = 3'd2,
		PH_CONFIG   = 3'd3,
		PH_CHECKSUM = 3'd4,
		PH_BCAST    = 3'd5,
		PH_UCAST    = 3'd6,
		PH_DISCARD  = 3'd7
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] tick_q, tick_d;
	logic [7:0] overhead_q, overhead_d;
	logic [7:0] config_q, config_d;
	logic [7:0] cslow_q, cslow_d;
	logic       cscnt_q, cscnt_d;
	logic [2:0] target_q, target_d;

	logic       accept;
	logic [7:0] b;
	logic [zdpr_pkg::MASK_W-1:0] live;
	logic [zdpr_pkg::MASK_W:0]   live_ext;
	logic [2:0] sel, sel_m1;
	logic       tmo_en;
	logic [7:0] tmo_limit;
	phase_t     tmo_next;
	logic [zdpr_pkg::MASK_W-1:0] target_oh, sel_oh;

	assign host_stall = q_full;
	assign accept     = host_valid && !q_full;
	assign b          = host_word.data_byte;
	assign live       = zdpr_pkg::live_ports(host_word.connected_mask);
	assign live_ext   = {1'b0, live};
	assign sel        = b[6:4];
	assign sel_m1     = sel - 3'd1;

	always_comb begin
		target_oh = '0;
		sel_oh    = '0;
		for (int i = 0; i < zdpr_pkg::MASK_W; i++) begin
			target_oh[i] = (target_q == 3'(i));
			sel_oh[i]    = (sel_m1 == 3'(i));
		end
	end

	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		overhead_d = overhead_q;
		config_d   = config_q;
		cslow_d    = cslow_q;
		cscnt_d    = cscnt_q;
		target_d   = target_q;
		push       = '0;
		tmo_en     = 1'b0;
		tmo_limit  = cfg.header_to;
		tmo_next   = PH_DISCARD;

		if (accept && host_word.operation) begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_FIRST: begin
					tmo_en = 1'b1; tmo_limit = cfg.first_to; tmo_next = PH_IDLE;
				end
				PH_RETRY: begin
					phase_d = PH_IDLE; tick_d = '0;
				end
				PH_CONFIG, PH_CHECKSUM: begin
					tmo_en = 1'b1; tmo_limit = cfg.header_to;
				end
				PH_BCAST: begin
					tmo_en = 1'b1; tmo_limit = cfg.bcast_to;
				end
				PH_UCAST: begin
					tmo_en = 1'b1; tmo_limit = cfg.body_to;
				end
				PH_DISCARD: begin
					tmo_en = 1'b1; tmo_limit = cfg.discard_to; tmo_next = PH_IDLE;
				end
			endcase
			if (tmo_en) begin
				if (tick_q >= tmo_limit) begin
					phase_d = tmo_next;
					tick_d  = '0;
				end else begin
					tick_d = tick_q + 8'd1;
				end
			end
		end else if (accept) begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_d = (b == 8'd0) ? PH_FIRST : PH_DISCARD;
					tick_d  = '0;
				end
				PH_FIRST, PH_RETRY: begin
					tick_d = '0;
					if (b == 8'd0) begin
						phase_d = (phase_q == PH_FIRST) ? PH_RETRY : PH_IDLE;
					end else begin
						overhead_d = b;
						phase_d    = (b == zdpr_pkg::ERR_FIRST) ? PH_DISCARD : PH_CONFIG;
					end
				end
				PH_CONFIG: begin
					config_d = b;
					tick_d   = '0;
					if (b == cfg.bcast_code) begin
						cscnt_d = 1'b0;
						phase_d = PH_CHECKSUM;
					end else if (sel == 3'd0 || 32'(sel) > zdpr_pkg::NUM_PORTS ||
						!live_ext[sel_m1]) begin
						phase_d = PH_DISCARD;
					end else begin
						target_d        = sel_m1;
						push.valid      = 1'b1;
						push.cmd.kind   = zdpr_pkg::CMD_UNI;
						push.cmd.mask   = sel_oh;
						push.cmd.byte0  = overhead_q;
						push.cmd.cfg    = b;
						phase_d         = PH_UCAST;
					end
				end
				PH_CHECKSUM: begin
					if (!cscnt_q) begin
						cslow_d = b;
						cscnt_d = 1'b1;
					end else begin
						cscnt_d         = 1'b0;
						push.valid      = (live != '0);
						push.cmd.kind   = zdpr_pkg::CMD_BCAST;
						push.cmd.mask   = live;
						push.cmd.byte0  = overhead_q;
						push.cmd.cfg    = config_q;
						push.cmd.cs     = {b, cslow_q};
						phase_d         = PH_BCAST;
						tick_d          = '0;
					end
				end
				PH_BCAST, PH_UCAST: begin
					push.valid     = (phase_q == PH_UCAST) || (live != '0);
					push.cmd.kind  = zdpr_pkg::CMD_BODY;
					push.cmd.mask  = (phase_q == PH_UCAST) ? target_oh : live;
					push.cmd.byte0 = b;
					if (b == 8'd0) begin
						phase_d = PH_IDLE;
						tick_d  = '0;
					end
				end
				PH_DISCARD: begin
					if (b == 8'd0) begin
						phase_d = PH_IDLE;
						tick_d  = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			overhead_q <= '0;
			config_q   <= '0;
			cslow_q    <= '0;
			cscnt_q    <= 1'b0;
			target_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			overhead_q <= overhead_d;
			config_q   <= config_d;
			cslow_q    <= cslow_d;
			cscnt_q    <= cscnt_d;
			target_q   <= target_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/zdpr_back.sv =====
// Result generator: expands queued jobs into port words, one word per cycle unless port_stall holds it.
`default_nettype none
module zdpr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire zdpr_pkg::cmd_t  head,
	input  wire logic            head_valid,
	output logic                 pop,
	output logic                 port_valid,
	output zdpr_pkg::port_word_t port_word,
	input  wire logic            port_stall
);
	localparam logic [2:0] W_UNI_LAST   = 3'd2;
	localparam logic [2:0] W_CS_LOW     = 3'd3;
	localparam logic [2:0] W_BCAST_LAST = 3'd4;

	logic                        started_q;
	logic [zdpr_pkg::MASK_W-1:0] rem_q, rem_eff, lowbit, rem_next;
	logic [2:0]                  widx_q, port_idx;
	logic                        out_valid_q;
	zdpr_pkg::port_word_t        out_word_q, word;
	logic                        adv, emit, port_done;
	logic [7:0]                  add;
	logic [15:0]                 cs_adj;

	assign rem_eff  = started_q ? rem_q : head.mask;
	assign lowbit   = rem_eff & (~rem_eff + zdpr_pkg::MASK_W'(1));
	assign rem_next = rem_eff & ~lowbit;

	always_comb begin
		port_idx = '0;
		for (int i = zdpr_pkg::MASK_W - 1; i >= 0; i--) begin
			if (rem_eff[i]) begin
				port_idx = 3'(i);
			end
		end
	end

	// port number lands in bits 6:4 of config and checksum
	assign add    = {1'b0, port_idx + 3'd1, 4'b0000};
	assign cs_adj = head.cs + {8'b0, add};

	always_comb begin
		word      = '0;
		port_done = 1'b0;
		case (head.kind)
			zdpr_pkg::CMD_UNI: begin
				word.port_mask = head.mask;
				case (widx_q)
					3'd0:    word.out_byte = 8'd0;
					3'd1:    word.out_byte = head.byte0;
					default: word.out_byte = head.cfg;
				endcase
				word.last = (widx_q == W_UNI_LAST);
			end
			zdpr_pkg::CMD_BCAST: begin
				word.port_mask = lowbit;
				case (widx_q)
					3'd0:     word.out_byte = 8'd0;
					3'd1:     word.out_byte = head.byte0;
					3'd2:     word.out_byte = head.cfg + add;
					W_CS_LOW: word.out_byte = cs_adj[7:0];
					default:  word.out_byte = cs_adj[15:8];
				endcase
				port_done = (widx_q == W_BCAST_LAST);
				word.last = port_done && (rem_next == '0);
			end
			default: begin
				word.port_mask = head.mask;
				word.out_byte  = head.byte0;
				word.last      = 1'b1;
			end
		endcase
	end

	assign adv        = !out_valid_q || !port_stall;
	assign emit       = adv && head_valid;
	assign pop        = emit && word.last;
	assign port_valid = out_valid_q;
	assign port_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			rem_q       <= '0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (word.last) begin
					started_q <= 1'b0;
					widx_q    <= '0;
				end else if (port_done) begin
					started_q <= 1'b1;
					rem_q     <= rem_next;
					widx_q    <= '0;
				end else begin
					started_q <= 1'b1;
					rem_q     <= rem_eff;
					widx_q    <= widx_q + 3'd1;
				end
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_word_q <= word;
		end
	end

endmodule
`default_nettype wire

// ===== design/zero_delimited_packet_router_unit.sv =====
// Top level of the zero-delimited packet router: config registers, parser, queue, generator.
`default_nettype none
// Routes zero-delimited host packets to up to six downstream ports. Each host
// word is either a received byte or a millisecond tick. The parser front end
// takes one host word per clock as long as its job queue (QUEUE_DEPTH entries)
// has room; host_stall is simply "queue full". Ticks and header bytes that
// produce nothing never occupy the queue. The generator back end emits one
// port word per clock unless port_stall holds it, from the queue head into an
// output register: a unicast header is 3 words, a broadcast header is 5 words
// per connected port (up to 30), and each body byte is 1 word routed to one
// port or to all connected ports. So body traffic flows at one host word per
// clock unless the ports stall; a header burst can fill the queue and stall
// the front end. The last field marks the final port word of one host word.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only be changed while no packet is in flight.
module zero_delimited_packet_router_unit #(
	parameter int QUEUE_DEPTH = zdpr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [7:0]           cfg_data,
	input  wire logic                 host_valid,
	input  wire zdpr_pkg::host_word_t host_word,
	output logic                      host_stall,
	output logic                      port_valid,
	output zdpr_pkg::port_word_t      port_word,
	input  wire logic                 port_stall
);
	zdpr_pkg::cfg_t  cfg_q;
	zdpr_pkg::push_t push;
	zdpr_pkg::cmd_t  head;
	logic            q_nonempty, q_full, pop;

	// config registers, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_to   <= zdpr_pkg::RST_FIRST_TO;
			cfg_q.header_to  <= zdpr_pkg::RST_HEADER_TO;
			cfg_q.bcast_to   <= zdpr_pkg::RST_BCAST_TO;
			cfg_q.body_to    <= zdpr_pkg::RST_BODY_TO;
			cfg_q.discard_to <= zdpr_pkg::RST_DISCARD_TO;
			cfg_q.bcast_code <= zdpr_pkg::RST_BCAST_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zdpr_pkg::REG_FIRST_TO:   cfg_q.first_to   <= cfg_data;
				zdpr_pkg::REG_HEADER_TO:  cfg_q.header_to  <= cfg_data;
				zdpr_pkg::REG_BCAST_TO:   cfg_q.bcast_to   <= cfg_data;
				zdpr_pkg::REG_BODY_TO:    cfg_q.body_to    <= cfg_data;
				zdpr_pkg::REG_DISCARD_TO: cfg_q.discard_to <= cfg_data;
				zdpr_pkg::REG_BCAST_CODE: cfg_q.bcast_code <= cfg_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	zdpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.host_valid (host_valid),
		.host_word  (host_word),
		.host_stall (host_stall),
		.q_full     (q_full),
		.push       (push)
	);

	zdpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head     (head),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	zdpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_nonempty),
		.pop        (pop),
		.port_valid (port_valid),
		.port_word  (port_word),
		.port_stall (port_stall)
	);

	// a job is never offered to a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && q_full))
		else $error("job pushed into full queue");

	// every port word goes to at least one existing port
	a_mask_sane: assert property (@(posedge clk) disable iff (!arst_n)
		port_valid |-> (port_word.port_mask != '0) &&
		((port_word.port_mask & ~zdpr_pkg::LIVE_MASK) == '0))
		else $error("port word with empty or out-of-range mask");

	// a fresh port word needs a job that was queued
	a_word_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(port_valid) |-> $past(q_nonempty))
		else $error("port word without a queued job");

endmodule
`default_nettype wire
